FILE: sv/rpoc_pkg.sv
`default_nettype none

package rpoc_pkg;

    // default sizes
    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // field widths
    localparam int MODE_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int SHIFT_W     = 16;
    localparam int SHIFT_CNT_W = $clog2(SHIFT_W);
    localparam int TOTAL_W     = 16;

    // result packing: match_here, total_matches, pattern_overflow
    localparam int OUT_MATCH_BIT = 0;
    localparam int OUT_TOTAL_LSB = 1;
    localparam int OUT_TOTAL_MSB = OUT_TOTAL_LSB + TOTAL_W - 1;
    localparam int OUT_OVF_BIT   = OUT_TOTAL_MSB + 1;
    localparam int OUT_FIELDS_W  = OUT_OVF_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // register map
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = PADDR_W - 2;
    localparam int REG_SHIFT_COUNT = 0;

    // character constants
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [MODE_W-1:0] {
        MODE_PATTERN = 2'd0,
        MODE_TEXT    = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SWEEP,
        ST_DRAIN,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic exec_now;
        logic exec_held;
        logic hold_byte;
        logic div_start;
        logic div_step;
        logic sweep_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic offset_ready;
        logic len_zero;
        logic div_last;
        logic sweep_last;
    } ctrl_stat_t;

    function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
    endfunction

endpackage

`default_nettype wire

FILE: sv/rotated_pattern_occurrence_counter_core.sv
`default_nettype none

// channel   | direction | tdata (lsb first)                          | tuser
// ----------+-----------+--------------------------------------------+------------------
// s_ input  | in        | [7:0] byte_value                           | [1:0] mode
// m_ result | out       | [0] match_here, [16:1] total_matches,      | none
//           |           | [17] pattern_overflow, [23:18] zero        |
// apb       | in/out    | 0x0 shift_count [15:0]                     |
//
// a pattern, clear or text request is normally executed as it is taken, one request per clock
//   while the output register is free; the first text request after a pattern change is held
//   while the remainder unit works out the rotation offset (one bit of shift_count per cycle),
//   the rotated pattern is copied byte by byte out of the pattern ram, and then the drain
//   state and the execute state follow; the execute state waits for a free output register
// aresetn is synchronous, active low; it clears shift_count, the pattern length,
//   the word run and the match total
// a result waits in an output register; a new request is taken while the result
//   is being taken or the register is empty

module rotated_pattern_occurrence_counter_core #(
    parameter int MAX_PATTERN = rpoc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = rpoc_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rpoc_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] byte_value
    input  logic [rpoc_pkg::MODE_W-1:0]       s_tuser,   // [1:0] mode
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rpoc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] match_here, [16:1] total_matches,
                                                         // [17] pattern_overflow
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rpoc_pkg::PADDR_W-1:0]      paddr,
    input  logic [rpoc_pkg::PDATA_W-1:0]      pwdata,
    output logic [rpoc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    import rpoc_pkg::*;

    ctrl_cmd_t             cmd;
    ctrl_stat_t            stat;
    logic [SHIFT_W-1:0]    shift_count_reg;
    logic                  reg_hit;

    // register decode, word aligned
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_IDX_W'(REG_SHIFT_COUNT));
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(shift_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_count_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            shift_count_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    // sequencing of requests, remainder unit and rotation sweep
    rpoc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pattern ram, window compare, counters and result register
    rpoc_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser),
        .in_byte     (s_tdata),
        .shift_count (shift_count_reg),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_data    (m_tdata)
    );

    // a pattern request always invalidates the latched rotation
    a_pattern_drops_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == MODE_PATTERN) |=> !stat.offset_ready)
        else $error("rotation offset still marked ready after pattern request");

    // a reported occurrence always leaves a nonzero total
    a_match_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_MATCH_BIT]) |-> (m_tdata[OUT_TOTAL_MSB:OUT_TOTAL_LSB] != '0))
        else $error("match reported with zero total");

    // overflow and match come from different request kinds
    a_match_ovf_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_MATCH_BIT] && m_tdata[OUT_OVF_BIT]))
        else $error("match and overflow on one result");

    // no request is taken while the rotation is being worked out
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step || cmd.sweep_step) |-> !s_tready)
        else $error("request taken during rotation setup");

endmodule

`default_nettype wire

FILE: sv/rpoc_ram.sv
`default_nettype none

module rpoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/rpoc_ctrl.sv
`default_nettype none

module rpoc_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic [rpoc_pkg::MODE_W-1:0]       s_mode,
    output logic                              s_tready,
    input  rpoc_pkg::ctrl_stat_t              stat,
    output rpoc_pkg::ctrl_cmd_t               cmd
);

    import rpoc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    // first text byte after a pattern change needs the rotation
                    if (s_mode == MODE_TEXT && !stat.offset_ready && !stat.len_zero) begin
                        cmd.hold_byte = 1'b1;
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.exec_now = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/rpoc_dp.sv
`default_nettype none

module rpoc_dp #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 16,
    localparam int LEN_W      = $clog2(MAX_PATTERN + 1),
    localparam int AW         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rpoc_pkg::ctrl_cmd_t                cmd,
    output rpoc_pkg::ctrl_stat_t               stat,
    input  logic [rpoc_pkg::MODE_W-1:0]        in_mode,
    input  logic [rpoc_pkg::BYTE_W-1:0]        in_byte,
    input  logic [rpoc_pkg::SHIFT_W-1:0]       shift_count,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [rpoc_pkg::OUT_TDATA_W-1:0]   out_data
);

    import rpoc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // pattern length, offset and word state
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  offset_ready_reg, offset_ready_next;
    logic [LEN_W-1:0]      offset_reg;
    logic [LEN_W-1:0]      run_reg, run_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]     byte_reg;

    // remainder unit
    logic [SHIFT_CNT_W-1:0] div_cnt_reg;
    logic [LEN_W-1:0]       rem_reg;
    logic [LEN_W:0]         trial;
    logic [LEN_W-1:0]       rem_step;

    // rotation sweep
    logic [LEN_W-1:0] sweep_idx_reg;
    logic             rd_valid_reg;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W:0]   pos_sum;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] kpos;
    logic [BYTE_W-1:0] ram_rdata;

    // rotated pattern and text window, entry 0 newest
    logic [BYTE_W-1:0] rot_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] win_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] win_shift [MAX_PATTERN];
    logic              win_shift_en;

    // item execution
    logic              exec;
    logic [MODE_W-1:0] ex_mode;
    logic [BYTE_W-1:0] ex_byte;
    logic [LEN_W-1:0]  run_inc;
    logic              all_eq;
    logic              win_hit;
    logic              hit;
    logic              ovf;
    logic              ram_we;

    // result register
    logic               out_valid_reg;
    logic               match_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               ovf_reg;

    rpoc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (lower_byte(ex_byte)),
        .raddr (sweep_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // one remainder bit per cycle, msb first
    assign trial    = {rem_reg, shift_count[div_cnt_reg]};
    assign rem_step = (trial >= {1'b0, len_reg}) ? LEN_W'(trial - {1'b0, len_reg})
                                                 : trial[LEN_W-1:0];

    // pattern entry src lands at window slot len-1-((src+offset) mod len)
    assign pos_sum = {1'b0, rd_idx_reg} + {1'b0, offset_reg};
    assign pos     = (pos_sum >= {1'b0, len_reg}) ? LEN_W'(pos_sum - {1'b0, len_reg})
                                                  : pos_sum[LEN_W-1:0];
    assign kpos    = len_reg - LEN_W'(1) - pos;

    assign exec    = cmd.exec_now | cmd.exec_held;
    assign ex_mode = cmd.exec_held ? MODE_W'(MODE_TEXT) : in_mode;
    assign ex_byte = cmd.exec_held ? byte_reg : in_byte;
    assign run_inc = (run_reg < MAX_LEN) ? run_reg + LEN_W'(1) : run_reg;

    always_comb begin
        win_shift[0] = ex_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_shift[k] = win_reg[k-1];
        end
    end

    always_comb begin
        all_eq = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_W'(k) < len_reg && rot_reg[k] != win_shift[k]) begin
                all_eq = 1'b0;
            end
        end
        win_hit = (len_reg != '0) && (run_inc >= len_reg) && all_eq;
    end

    always_comb begin
        len_next          = len_reg;
        offset_ready_next = offset_ready_reg;
        run_next          = run_reg;
        count_next        = count_reg;
        win_shift_en      = 1'b0;
        hit               = 1'b0;
        ovf               = 1'b0;
        ram_we            = 1'b0;
        if (exec) begin
            case (ex_mode)
                MODE_PATTERN: begin
                    if (len_reg < MAX_LEN) begin
                        len_next = len_reg + LEN_W'(1);
                        ram_we   = 1'b1;
                    end else begin
                        ovf = 1'b1;
                    end
                    offset_ready_next = 1'b0;
                end
                MODE_TEXT: begin
                    offset_ready_next = 1'b1;
                    if (is_blank(ex_byte)) begin
                        run_next = '0;
                    end else begin
                        win_shift_en = 1'b1;
                        run_next     = run_inc;
                        hit          = win_hit;
                        if (win_hit && count_reg != '1) begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end
                end
                MODE_CLEAR: begin
                    len_next          = '0;
                    offset_ready_next = 1'b0;
                    run_next          = '0;
                    count_next        = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg          <= '0;
            offset_ready_reg <= 1'b0;
            run_reg          <= '0;
            count_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            len_reg          <= len_next;
            offset_ready_reg <= offset_ready_next;
            run_reg          <= run_next;
            count_reg        <= count_next;
            rd_valid_reg     <= cmd.sweep_step;
            if (exec) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hold_byte) begin
            byte_reg <= in_byte;
        end
        if (cmd.div_start) begin
            rem_reg     <= '0;
            div_cnt_reg <= SHIFT_CNT_W'(SHIFT_W - 1);
        end else if (cmd.div_step) begin
            rem_reg     <= rem_step;
            div_cnt_reg <= div_cnt_reg - SHIFT_CNT_W'(1);
            if (stat.div_last) begin
                offset_reg    <= rem_step;
                sweep_idx_reg <= '0;
            end
        end
        if (cmd.sweep_step) begin
            sweep_idx_reg <= sweep_idx_reg + LEN_W'(1);
            rd_idx_reg    <= sweep_idx_reg;
        end
        if (rd_valid_reg) begin
            rot_reg[kpos[AW-1:0]] <= ram_rdata;
        end
        if (win_shift_en) begin
            win_reg <= win_shift;
        end
        if (exec) begin
            match_reg <= hit;
            total_reg <= TOTAL_W'(count_next);
            ovf_reg   <= ovf;
        end
    end

    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.offset_ready = offset_ready_reg;
    assign stat.len_zero     = (len_reg == '0);
    assign stat.div_last     = (div_cnt_reg == '0);
    assign stat.sweep_last   = (sweep_idx_reg == len_reg - LEN_W'(1));

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, ovf_reg, total_reg, match_reg};

endmodule

`default_nettype wire
